>>> design/pft_pkg.sv
// shared types and constants for the prime filter trial division unit
package pft_pkg;

   // classification carried with each value from front to back
   typedef struct packed {
      logic trivial;   // verdict settled by the front, no trial division needed
      logic verdict;   // prime flag when trivial is set
      logic last;      // end-of-matrix marker of the beat
   } pft_tag_type;

   localparam int TAG_WIDTH = $bits(pft_tag_type);

   // first trial divisor and the smallest value that can be prime
   localparam int FIRST_DIVISOR = 2;
   localparam int LOWEST_PRIME  = 2;
   localparam int SMALL_PRIME   = 3;

endpackage

>>> design/pft_front.sv
// front stage: takes input beats, settles the trivial cases and feeds the queue
module pft_front import pft_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_last_element,
   output logic                   q_push,
   input  logic                   q_full,
   output logic [VALUE_WIDTH-1:0] q_value,
   output pft_tag_type            q_tag
);

   logic                   hold_valid_ff, hold_valid_in;
   logic [VALUE_WIDTH-1:0] hold_value_ff, hold_value_in;
   pft_tag_type            hold_tag_ff, hold_tag_in;
   logic                   accept;
   logic                   negative;
   logic                   below_two;
   logic                   small_prime;

   assign full   = hold_valid_ff & q_full;
   assign accept = push & ~full;
   assign q_push = hold_valid_ff;
   assign q_value = hold_value_ff;
   assign q_tag   = hold_tag_ff;

   always_comb begin
      negative    = req_value[VALUE_WIDTH-1];
      below_two   = req_value < VALUE_WIDTH'(LOWEST_PRIME);
      small_prime = (req_value == VALUE_WIDTH'(LOWEST_PRIME)) ||
                    (req_value == VALUE_WIDTH'(SMALL_PRIME));
      hold_valid_in = accept | (hold_valid_ff & q_full);
      hold_value_in = hold_value_ff;
      hold_tag_in   = hold_tag_ff;
      if (accept) begin
         hold_value_in       = req_value;
         hold_tag_in.trivial = negative | below_two | small_prime;
         hold_tag_in.verdict = small_prime;
         hold_tag_in.last    = req_last_element;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_value_ff <= hold_value_in;
      hold_tag_ff   <= hold_tag_in;
   end

endmodule

>>> design/pft_queue.sv
// short first-in first-out queue between the front and the back
module pft_queue #(
   parameter int DATA_WIDTH = 35,
   parameter int DEPTH      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   output logic                  q_full,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   output logic                  q_empty,
   output logic [DATA_WIDTH-1:0] rd_data
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]  count_ff, count_in;
   logic                  do_wr;
   logic                  do_rd;

   assign q_full  = count_ff == CNT_WIDTH'(DEPTH);
   assign q_empty = count_ff == '0;
   assign do_wr   = wr_en & ~q_full;
   assign do_rd   = rd_en & ~q_empty;
   assign rd_data = rd_data_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
      // head entry prefetched from the next read pointer, new data bypassed in
      rd_data_ff <= (do_wr && (wr_ptr_ff == rd_ptr_in)) ? wr_data : mem_ff[rd_ptr_in];
   end

endmodule

>>> design/pft_back.sv
// back stage: trial division sequencer with a bit-serial remainder unit
module pft_back import pft_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   output logic                   q_pop,
   input  logic [VALUE_WIDTH-1:0] q_value,
   input  pft_tag_type            q_tag,
   output logic                   empty,
   input  logic                   pop,
   output logic [VALUE_WIDTH-1:0] rsp_tested_value,
   output logic                   rsp_prime_flag,
   output logic                   rsp_end_of_matrix
);

   localparam int W  = VALUE_WIDTH;
   localparam int CW = $clog2(W);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [W-1:0]   value_ff, value_in;
   logic           last_ff, last_in;
   logic [W-1:0]   dividend_ff, dividend_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   div_ff, div_in;
   logic [2*W-1:0] sq_ff, sq_in;
   logic [CW-1:0]  bit_ff, bit_in;
   logic           verdict_ff, verdict_in;
   logic           out_valid_ff, out_valid_in;
   logic [W-1:0]   out_value_ff, out_value_in;
   logic           out_prime_ff, out_prime_in;
   logic           out_last_ff, out_last_in;
   logic [W:0]     trial;
   logic [W:0]     trial_sub;
   logic           out_free;
   logic           load_out;

   assign empty             = ~out_valid_ff;
   assign rsp_tested_value  = out_value_ff;
   assign rsp_prime_flag    = out_prime_ff;
   assign rsp_end_of_matrix = out_last_ff;
   assign out_free          = ~out_valid_ff | pop;
   assign q_pop             = (state_ff == ST_IDLE) & ~q_empty;

   always_comb begin
      trial     = {rem_ff, dividend_ff[W-1]};
      trial_sub = trial - {1'b0, div_ff};
      load_out  = (state_ff == ST_DONE) & out_free;

      state_in    = state_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      sq_in       = sq_ff;
      bit_in      = bit_ff;
      verdict_in  = verdict_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               value_in   = q_value;
               last_in    = q_tag.last;
               verdict_in = q_tag.verdict;
               div_in     = W'(FIRST_DIVISOR);
               sq_in      = (2*W)'(FIRST_DIVISOR * FIRST_DIVISOR);
               state_in   = q_tag.trivial ? ST_DONE : ST_CHECK;
            end
         end
         ST_CHECK: begin
            // no divisor left with d*d <= value: prime
            if (sq_ff > {{W{1'b0}}, value_ff}) begin
               verdict_in = 1'b1;
               state_in   = ST_DONE;
            end else begin
               dividend_in = value_ff;
               rem_in      = '0;
               bit_in      = '0;
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // one restoring remainder bit per cycle, msb first
            rem_in      = (trial >= {1'b0, div_ff}) ? trial_sub[W-1:0] : trial[W-1:0];
            dividend_in = {dividend_ff[W-2:0], 1'b0};
            bit_in      = bit_ff + 1'b1;
            if (bit_ff == CW'(W - 1)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (rem_ff == '0) begin
               verdict_in = 1'b0;
               state_in   = ST_DONE;
            end else begin
               // (d+1)^2 = d^2 + 2d + 1
               sq_in    = sq_ff + {{(W-1){1'b0}}, div_ff, 1'b1};
               div_in   = div_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff & ~pop;
      out_value_in = out_value_ff;
      out_prime_in = out_prime_ff;
      out_last_in  = out_last_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_value_in = value_ff;
         out_prime_in = verdict_ff;
         out_last_in  = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      value_ff     <= value_in;
      last_ff      <= last_in;
      dividend_ff  <= dividend_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      bit_ff       <= bit_in;
      verdict_ff   <= verdict_in;
      out_value_ff <= out_value_in;
      out_prime_ff <= out_prime_in;
      out_last_ff  <= out_last_in;
   end

`ifndef ASSERT_OFF
   // partial remainder always stays below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_STEP) |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");

   // running square tracks the divisor
   a_square_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |->
         (sq_ff == ({{W{1'b0}}, div_ff} * {{W{1'b0}}, div_ff})))
      else $error("divisor square out of step");

   // divisor never drops below the first trial divisor during a test
   a_div_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK || state_ff == ST_DIVIDE) |-> (div_ff >= W'(FIRST_DIVISOR)))
      else $error("trial divisor below two");

   // a prime result is positive and at least two
   a_prime_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_prime_ff) |->
         (!out_value_ff[W-1] && (out_value_ff >= W'(LOWEST_PRIME))))
      else $error("prime flag on a value that cannot be prime");
`endif

endmodule

>>> design/prime_filter_trial_division_unit.sv
// top level of the prime filter trial division unit
//
//   channel   ports                                       beat accepted when
//   -------   -----------------------------------------   ------------------
//   request   push full req_value req_last_element        push && !full
//   response  empty pop rsp_tested_value rsp_prime_flag   pop && !empty
//             rsp_end_of_matrix
//
// negative values, zero, one, two and three are settled by the front and pass
// through the queue and the back's done state into the response register
// other values are divided by every trial divisor d from two while d*d <= value;
// a composite stops at its first factor, and the bit-serial remainder unit works
// one remainder bit per cycle, VALUE_WIDTH bits for every trial divisor
// reset is synchronous and active high, and clears the queue and all valid flags
// the front keeps accepting beats into its queue while the back works or a
// response waits; full rises only when both the queue and the front register are taken
module prime_filter_trial_division_unit import pft_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // request beats
   input  logic                   push,
   output logic                   full,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic                   req_last_element,
   // response beats
   output logic                   empty,
   input  logic                   pop,
   output logic [VALUE_WIDTH-1:0] rsp_tested_value,
   output logic                   rsp_prime_flag,
   output logic                   rsp_end_of_matrix
);

   localparam int ENTRY_WIDTH = VALUE_WIDTH + TAG_WIDTH;

   // front to queue
   logic                   f_push;
   logic                   f_full;
   logic [VALUE_WIDTH-1:0] f_value;
   pft_tag_type            f_tag;

   // queue to back
   logic                   b_pop;
   logic                   b_empty;
   logic [ENTRY_WIDTH-1:0] b_entry;
   logic [VALUE_WIDTH-1:0] b_value;
   pft_tag_type            b_tag;

   assign b_value = b_entry[ENTRY_WIDTH-1:TAG_WIDTH];
   assign b_tag   = pft_tag_type'(b_entry[TAG_WIDTH-1:0]);

   // classifier: settles sign, zero, one, two and three on the spot
   pft_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_value        (req_value),
      .req_last_element (req_last_element),
      .q_push           (f_push),
      .q_full           (f_full),
      .q_value          (f_value),
      .q_tag            (f_tag)
   );

   // decoupling queue, value and tag packed side by side
   pft_queue #(
      .DATA_WIDTH (ENTRY_WIDTH),
      .DEPTH      (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (f_push),
      .q_full  (f_full),
      .wr_data ({f_value, f_tag}),
      .rd_en   (b_pop),
      .q_empty (b_empty),
      .rd_data (b_entry)
   );

   // trial division sequencer with its response register
   pft_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (b_empty),
      .q_pop             (b_pop),
      .q_value           (b_value),
      .q_tag             (b_tag),
      .empty             (empty),
      .pop               (pop),
      .rsp_tested_value  (rsp_tested_value),
      .rsp_prime_flag    (rsp_prime_flag),
      .rsp_end_of_matrix (rsp_end_of_matrix)
   );

endmodule

>>> sim/tb_top.sv
// self-checking testbench for the prime filter trial division unit
module tb_top import pft_pkg::*; ();

   localparam int VALUE_WIDTH  = 32;
   localparam int PROBE_COUNT  = 22;
   localparam int RANDOM_BEATS = 100;
   // no stalls on either side for the final stretch of random beats
   localparam int CALM_BEATS   = 20;
   // idle time after the last expected response, so any stray response is caught
   localparam int DRAIN_CYCLES = 40;

   // one expected response beat
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   prime;
      logic                   last;
   } verdict_type;

   // directed row: typed is set where the verdict is obvious and written in by hand
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   last;
      logic                   typed;
      logic                   prime;
   } probe_row_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   push             = 1'b0;
   logic                   full;
   logic [VALUE_WIDTH-1:0] req_value        = '0;
   logic                   req_last_element = 1'b0;
   logic                   empty;
   logic                   pop              = 1'b0;
   logic [VALUE_WIDTH-1:0] rsp_tested_value;
   logic                   rsp_prime_flag;
   logic                   rsp_end_of_matrix;

   verdict_type pending_verdicts [$];
   int       failures       = 0;
   int       beats_sent     = 0;
   int       beats_checked  = 0;
   int       primes_seen    = 0;
   int       matrix_ends    = 0;
   bit       quiet_tail     = 1'b0;

   // directed rows: range extremes, the trivial verdicts, squares of primes
   // (divisor squared equal to the value), and the largest positive value,
   // which is a prime and walks the divisor bound right up to the top
   probe_row_type probe_rows [0:PROBE_COUNT-1] = '{
      '{32'd0,            1'b0, 1'b1, 1'b0},
      '{32'd1,            1'b0, 1'b1, 1'b0},
      '{32'd2,            1'b0, 1'b1, 1'b1},
      '{32'd3,            1'b1, 1'b1, 1'b1},
      '{32'd4,            1'b0, 1'b1, 1'b0},
      '{32'hFFFF_FFFF,    1'b0, 1'b1, 1'b0},
      '{32'h8000_0000,    1'b1, 1'b1, 1'b0},
      '{32'hAAAA_AAAA,    1'b0, 1'b1, 1'b0},
      '{32'd2147483646,   1'b0, 1'b1, 1'b0},
      '{32'd2147483647,   1'b1, 1'b1, 1'b1},
      '{32'd9,            1'b0, 1'b0, 1'b0},
      '{32'd25,           1'b0, 1'b0, 1'b0},
      '{32'd49,           1'b1, 1'b0, 1'b0},
      '{32'd121,          1'b0, 1'b0, 1'b0},
      '{32'd97,           1'b0, 1'b0, 1'b0},
      '{32'd5,            1'b0, 1'b0, 1'b0},
      '{32'd65537,        1'b0, 1'b0, 1'b0},
      '{32'd1000003,      1'b1, 1'b0, 1'b0},
      '{32'd2147483645,   1'b0, 1'b0, 1'b0},
      '{32'h5555_5555,    1'b0, 1'b0, 1'b0},
      '{32'd1073741824,   1'b0, 1'b0, 1'b0},
      '{32'd1073741827,   1'b1, 1'b0, 1'b0}
   };

   prime_filter_trial_division_unit #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_value        (req_value),
      .req_last_element (req_last_element),
      .empty            (empty),
      .pop              (pop),
      .rsp_tested_value (rsp_tested_value),
      .rsp_prime_flag   (rsp_prime_flag),
      .rsp_end_of_matrix(rsp_end_of_matrix)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // trial division with the bound kept as d <= n / d so nothing overflows
   function automatic logic predict_prime(logic [VALUE_WIDTH-1:0] v);
      longint unsigned n;
      longint unsigned d;
      n = 64'(v);
      if (v[VALUE_WIDTH-1]) return 1'b0;
      if (n < LOWEST_PRIME) return 1'b0;
      for (d = FIRST_DIVISOR; d <= n / d; d++) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // random value: mostly small, some medium, negatives, and large composites
   // with a small factor so the back end never grinds on a huge prime
   function automatic logic [VALUE_WIDTH-1:0] pick_value();
      int unsigned factor;
      int unsigned cofactor;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: pick_value = $urandom_range(0, 10007);
         4:          pick_value = $urandom_range(10008, 1 << 20);
         5, 6:       pick_value = {1'b1, 31'($urandom)};
         default: begin
            factor     = $urandom_range(2, 97);
            cofactor   = $urandom_range(1 << 20, 32'h7FFF_FFFF / factor);
            pick_value = factor * cofactor;
         end
      endcase
   endfunction

   // offer one request beat, with an occasional idle burst in front of it
   task automatic offer_beat(logic [VALUE_WIDTH-1:0] v, logic last, logic prime);
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      push             <= 1'b1;
      req_value        <= v;
      req_last_element <= last;
      // full is sampled before this edge's updates land
      do @(posedge clock); while (full);
      pending_verdicts.push_back('{value: v, prime: prime, last: last});
      beats_sent++;
   endtask

   // request side
   initial begin : stimulus
      logic [VALUE_WIDTH-1:0] v;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (probe_rows[i]) begin
         offer_beat(probe_rows[i].value, probe_rows[i].last,
                    probe_rows[i].typed ? probe_rows[i].prime
                                        : predict_prime(probe_rows[i].value));
      end

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i == RANDOM_BEATS - CALM_BEATS) quiet_tail = 1'b1;
         v = pick_value();
         offer_beat(v, $urandom_range(0, 7) == 0, predict_prime(v));
      end
      push <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request beats and %0d checked responses", beats_sent,
               beats_checked);
      $display("primes reported: %0d, end-of-matrix markers: %0d", primes_seen,
               matrix_ends);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // response side: pop with random stall bursts until the calm tail
   initial begin : drain
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            pop <= 1'b0;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // compare every accepted response beat against the oldest expectation
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && pop && !empty) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: response beat with nothing expected, value %0h", $time,
                     rsp_tested_value);
            failures++;
         end else begin
            want = pending_verdicts.pop_front();
            beats_checked++;
            if (rsp_prime_flag) primes_seen++;
            if (rsp_end_of_matrix) matrix_ends++;
            if (rsp_tested_value !== want.value) begin
               $display("%0t: tested_value expected %0h actual %0h", $time, want.value,
                        rsp_tested_value);
               failures++;
            end
            if (rsp_prime_flag !== want.prime) begin
               $display("%0t: prime flag for %0d expected %0b actual %0b", $time,
                        $signed(want.value), want.prime, rsp_prime_flag);
               failures++;
            end
            if (rsp_end_of_matrix !== want.last) begin
               $display("%0t: end_of_matrix expected %0b actual %0b", $time, want.last,
                        rsp_end_of_matrix);
               failures++;
            end
         end
      end
   end

   // watchdog: fails the run if it has not finished by the time limit
   initial begin : watchdog
      #300_000_000;
      $display("%0t: timeout with %0d responses outstanding", $time,
               pending_verdicts.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
